// ----- design/xs_pkg.sv -----
// Shared types and constants for the xoshiro256** generator unit.
// No dependencies; imported by xs_mul64_unit and xoshiro256ss_generator_unit.
package xs_pkg;

    typedef logic [63:0] t_word;
    typedef logic [31:0] t_half;

    localparam int unsigned NUM_WORDS = 4;

    localparam t_word C_GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
    localparam t_word C_MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
    localparam t_word C_MIX_MUL_B    = 64'h94d049bb133111eb;

    localparam t_word C_RESET_WORDS [NUM_WORDS] = '{
        64'h853c49e6748fea9b,
        64'hda3e39cb94b95bdb,
        64'h2545f4914f6cdd1d,
        64'h9e3779b97f4a7c15
    };

    // Handshake between the sequencer and the shared multiplier.
    typedef struct packed {
        logic  start;
        t_word a;
        t_word b;
    } t_mul_req;

    typedef struct packed {
        logic  done;
        t_word product;
    } t_mul_rsp;

endpackage

// ----- design/xs_mul64_unit.sv -----
// Iterative 64x64 multiplier returning the low 64 bits of the product.
// One 32x32 partial product per cycle, three partial products per operation. Uses xs_pkg.
module xs_mul64_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  xs_pkg::t_mul_req  i_req,
    output xs_pkg::t_mul_rsp  o_rsp
);
    import xs_pkg::*;

    typedef enum logic [2:0] {
        PP_LO_LO = 3'b001,
        PP_LO_HI = 3'b010,
        PP_HI_LO = 3'b100
    } t_pp_step;

    logic     r_busy, n_busy;
    logic     r_done, n_done;
    t_pp_step r_step, n_step;
    t_word    r_a, r_b;
    t_word    r_acc, n_acc;

    t_half    mul_x, mul_y;
    t_word    mul_p;

    always_comb begin
        unique case (r_step)
            PP_LO_LO: begin
                mul_x = r_a[31:0];
                mul_y = r_b[31:0];
            end
            PP_LO_HI: begin
                mul_x = r_a[31:0];
                mul_y = r_b[63:32];
            end
            PP_HI_LO: begin
                mul_x = r_a[63:32];
                mul_y = r_b[31:0];
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
        mul_p = 64'(mul_x) * 64'(mul_y);
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_acc  = r_acc;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_step = PP_LO_LO;
            n_acc  = '0;
        end else if (r_busy) begin
            unique case (r_step)
                PP_LO_LO: begin
                    n_acc  = r_acc + mul_p;
                    n_step = PP_LO_HI;
                end
                PP_LO_HI: begin
                    n_acc  = r_acc + {mul_p[31:0], 32'd0};
                    n_step = PP_HI_LO;
                end
                PP_HI_LO: begin
                    n_acc  = r_acc + {mul_p[31:0], 32'd0};
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end
                default: begin
                    n_busy = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= PP_LO_LO;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    // Operands and accumulator carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
        end
        r_acc <= n_acc;
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.product = r_acc;

endmodule

// ----- design/xoshiro256ss_generator_unit.sv -----
// Draw: a transfer passes ST_DRAW, then ST_DRAW_OUT, which waits for a free output register;
// the next item is taken only back in ST_IDLE. Reseed: each state word passes ST_MIX_ADD,
// ST_MIX_A and ST_MIX_B, paced by the shared multiplier that runs the two splitmix64 multiplies of each word.
// The input side is ready again while a finished draw waits in the output register.
// Reset (synchronous, active low) loads the four fixed state words and empties the output.
module xoshiro256ss_generator_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_cmd,
    input  xs_pkg::t_word    i_seed_value,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output xs_pkg::t_word    o_random_word
);
    import xs_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_DRAW     = 6'b000010,
        ST_DRAW_OUT = 6'b000100,
        ST_MIX_ADD  = 6'b001000,
        ST_MIX_A    = 6'b010000,
        ST_MIX_B    = 6'b100000
    } t_state;

    t_state   r_state, n_state;
    t_word    r_words [NUM_WORDS];
    t_word    n_words [NUM_WORDS];
    logic [1:0] r_idx, n_idx;
    t_word    r_ctr, n_ctr;
    t_word    r_z, n_z;
    logic     r_out_valid, n_out_valid;
    t_word    r_out_word, n_out_word;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;

    // Draw datapath
    t_word    w1_x5, w1_x5_rot;
    t_word    w2_a, w3_a, w1_n, w0_n, w2_n, w3_n;
    // Reseed datapath
    t_word    ctr_sum, mix_z0, mix_z1, mix_out;

    xs_mul64_unit u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    always_comb begin
        w1_x5     = r_words[1] + {r_words[1][61:0], 2'b00};
        w1_x5_rot = {w1_x5[56:0], w1_x5[63:57]};
        w2_a      = r_words[2] ^ r_words[0];
        w3_a      = r_words[3] ^ r_words[1];
        w1_n      = r_words[1] ^ w2_a;
        w0_n      = r_words[0] ^ w3_a;
        w2_n      = w2_a ^ {r_words[1][46:0], 17'd0};
        w3_n      = {w3_a[18:0], w3_a[63:19]};

        ctr_sum   = r_ctr + C_GOLDEN_GAMMA;
        mix_z0    = ctr_sum ^ {30'd0, ctr_sum[63:30]};
        mix_z1    = mul_rsp.product ^ {27'd0, mul_rsp.product[63:27]};
        mix_out   = mul_rsp.product ^ {31'd0, mul_rsp.product[63:31]};
    end

    always_comb begin
        n_state     = r_state;
        n_words     = r_words;
        n_idx       = r_idx;
        n_ctr       = r_ctr;
        n_z         = r_z;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        mul_req     = '{start: 1'b0, a: mix_z0, b: C_MIX_MUL_A};

        // Drop the output once it is taken.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_cmd) begin
                        n_ctr   = (i_seed_value == '0) ? C_GOLDEN_GAMMA : i_seed_value;
                        n_idx   = '0;
                        n_state = ST_MIX_ADD;
                    end else begin
                        n_state = ST_DRAW;
                    end
                end
            end
            ST_DRAW: begin
                n_z        = w1_x5_rot;
                n_words[0] = w0_n;
                n_words[1] = w1_n;
                n_words[2] = w2_n;
                n_words[3] = w3_n;
                n_state    = ST_DRAW_OUT;
            end
            ST_DRAW_OUT: begin
                // Hold until the output register is free.
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_word  = r_z + {r_z[60:0], 3'b000};
                    n_state     = ST_IDLE;
                end
            end
            ST_MIX_ADD: begin
                n_ctr         = ctr_sum;
                mul_req.start = 1'b1;
                n_state       = ST_MIX_A;
            end
            ST_MIX_A: begin
                if (mul_rsp.done) begin
                    mul_req = '{start: 1'b1, a: mix_z1, b: C_MIX_MUL_B};
                    n_state = ST_MIX_B;
                end
            end
            ST_MIX_B: begin
                if (mul_rsp.done) begin
                    n_words[r_idx] = mix_out;
                    n_idx          = r_idx + 2'd1;
                    n_state        = (r_idx == 2'(NUM_WORDS - 1)) ? ST_IDLE : ST_MIX_ADD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_words     <= C_RESET_WORDS;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            r_words     <= n_words;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctr      <= n_ctr;
        r_z        <= n_z;
        r_out_word <= n_out_word;
    end

    assign o_in_ready    = (r_state == ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_random_word = r_out_word;

endmodule

// ----- tb/xoshiro256ss_generator_unit_tb.sv -----
// Self-checking bench for xoshiro256ss_generator_unit: draws and reseeds are predicted
// in a small class and compared word by word with the block's results.
// Depends on xs_pkg (word type, reset words and splitmix64 constants).
module xoshiro256ss_generator_unit_tb;
    import xs_pkg::*;

    typedef enum logic {CMD_DRAW = 1'b0, CMD_RESEED = 1'b1} t_cmd;

    class xoshiro_predictor;
        t_word gen_state [NUM_WORDS];
        t_word due_words [$];
        int unsigned mismatches;
        int unsigned seen_words;

        function new();
            for (int i = 0; i < NUM_WORDS; i++) begin
                gen_state[i] = C_RESET_WORDS[i];
            end
            mismatches = 0;
            seen_words = 0;
        endfunction

        function t_word rotl(t_word v, int unsigned amt);
            return (v << amt) | (v >> (64 - amt));
        endfunction

        // Fill the four words from chained splitmix64 steps.
        function void reseed(t_word seed);
            t_word ctr;
            t_word z;
            ctr = (seed != '0) ? seed : C_GOLDEN_GAMMA;
            for (int i = 0; i < NUM_WORDS; i++) begin
                ctr = ctr + C_GOLDEN_GAMMA;
                z = ctr;
                z = (z ^ (z >> 30)) * C_MIX_MUL_A;
                z = (z ^ (z >> 27)) * C_MIX_MUL_B;
                gen_state[i] = z ^ (z >> 31);
            end
        endfunction

        // Output of the draw, then advance the state.
        function t_word draw();
            t_word word;
            t_word carry;
            word = rotl(gen_state[1] * 64'd5, 7) * 64'd9;
            carry = gen_state[1] << 17;
            gen_state[2] ^= gen_state[0];
            gen_state[3] ^= gen_state[1];
            gen_state[1] ^= gen_state[2];
            gen_state[0] ^= gen_state[3];
            gen_state[2] ^= carry;
            gen_state[3] = rotl(gen_state[3], 45);
            return word;
        endfunction

        function void note_input(t_cmd cmd, t_word seed);
            if (cmd == CMD_RESEED) begin
                reseed(seed);
            end else begin
                due_words.push_back(draw());
            end
        endfunction

        task report(string what, t_word got, t_word want);
            $display("mismatch at %0t: %s, got %h, expected %h", $realtime, what, got, want);
            mismatches++;
        endtask

        task check_word(t_word got);
            t_word want;
            seen_words++;
            if (due_words.size() == 0) begin
                report("random_word with no draw pending", got, '0);
            end else begin
                want = due_words.pop_front();
                if (got !== want) begin
                    report("random_word", got, want);
                end
            end
        endtask
    endclass

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_in_valid = 1'b0;
    logic  o_in_ready;
    logic  i_cmd = 1'b0;
    t_word i_seed_value = '0;
    logic  o_out_valid;
    logic  i_out_ready = 1'b0;
    t_word o_random_word;

    xoshiro_predictor gen_model = new();
    bit quiet_mode = 1'b0;
    int unsigned ready_left = 0;

    xoshiro256ss_generator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_seed_value  (i_seed_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_random_word (o_random_word)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_word rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // Mostly short gaps, a few long ones; none in quiet stretches.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (quiet_mode) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Called just after a rising edge; returns at the edge of the transfer.
    task automatic send_item(t_cmd cmd, t_word seed);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) begin
                @(posedge i_clk);
                i_cmd <= 1'($urandom_range(0, 1));
                i_seed_value <= rand_word();
            end
        end
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_seed_value <= seed;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        gen_model.note_input(cmd, seed);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (gen_model.due_words.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Result side: check each transfer, then pick the next ready level.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            gen_model.check_word(o_random_word);
        end
        if (ready_left == 0) begin
            if (quiet_mode || $urandom_range(0, 99) < 70) begin
                i_out_ready <= 1'b1;
                ready_left = $urandom_range(1, 8);
            end else begin
                i_out_ready <= 1'b0;
                ready_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(1, 3);
            end
        end else begin
            ready_left--;
        end
    end

    initial begin
        #20_000_000;
        $display("xoshiro256ss_generator_unit_tb: FAIL");
        $finish;
    end

    initial begin
        t_word seed;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: draws from the reset state, zero and extreme seeds,
        // back-to-back reseeds, and a seed equal to the default constant.
        repeat (4) send_item(CMD_DRAW, '0);
        send_item(CMD_RESEED, '0);
        repeat (2) send_item(CMD_DRAW, rand_word());
        send_item(CMD_RESEED, '1);
        repeat (2) send_item(CMD_DRAW, '1);
        send_item(CMD_RESEED, 64'd1);
        send_item(CMD_RESEED, 64'h8000_0000_0000_0000);
        repeat (2) send_item(CMD_DRAW, '0);
        send_item(CMD_RESEED, C_GOLDEN_GAMMA);
        send_item(CMD_DRAW, '0);
        send_item(CMD_RESEED, 64'h5555_5555_5555_5555);
        send_item(CMD_DRAW, '0);
        send_item(CMD_RESEED, 64'haaaa_aaaa_aaaa_aaaa);
        send_item(CMD_DRAW, '0);

        // Random phases; every third one runs without idling on either side.
        for (int phase = 0; phase < 13; phase++) begin
            quiet_mode = (phase % 3 == 1);
            for (int n = 0; n < 148; n++) begin
                if ($urandom_range(0, 99) < 8) begin
                    seed = ($urandom_range(0, 19) == 0) ? '0 : rand_word();
                    send_item(CMD_RESEED, seed);
                end else begin
                    send_item(CMD_DRAW, rand_word());
                end
            end
            if (phase == 0 || $urandom_range(0, 2) == 0) begin
                wait_drained();
            end
        end
        quiet_mode = 1'b0;

        wait_drained();
        repeat (60) @(posedge i_clk);

        if (gen_model.mismatches == 0 && gen_model.due_words.size() == 0) begin
            $display("xoshiro256ss_generator_unit_tb: PASS");
        end else begin
            $display("xoshiro256ss_generator_unit_tb: FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/xs_pkg.sv
design/xs_mul64_unit.sv
design/xoshiro256ss_generator_unit.sv
tb/xoshiro256ss_generator_unit_tb.sv
